/* rtl/fas_pkg.sv */
package fas_pkg;

  localparam int DATA_W = 8;
  // Offset from the sequence base: up to triple offset + 4
  localparam int REL_W  = 9;
  // Base plus offset before reduction into the table
  localparam int RAW_W  = 10;

  localparam logic [DATA_W-1:0] CODE_LOOP = 8'hff;
  localparam logic [DATA_W-1:0] CODE_HOLD = 8'hfe;
  localparam logic [DATA_W-1:0] CODE_END  = 8'hfd;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_START_DIFF,
    CMD_TICK
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MEM,
    ST_DATA
  } state_t;

  typedef enum logic [2:0] {
    P_WRITE,
    P_COUNT,
    P_OP,
    P_TARGET,
    P_POSE,
    P_HIT,
    P_END
  } phase_t;

endpackage

/* rtl/fas_ram.sv */
module fas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fas_addr_mod.sv */
// Reduce base + offset modulo the table depth: quotient by reciprocal multiply,
// registered with the input, then remainder by constant multiply.
module fas_addr_mod #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic [fas_pkg::RAW_W-1:0]      raw_i,
  output logic [$clog2(TABLE_DEPTH)-1:0] addr_o
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int SHIFT   = 20;
  localparam int MUL_W   = SHIFT + 1;
  localparam int DEP_W   = AW + 1;
  localparam int PROD_W  = fas_pkg::RAW_W + MUL_W;
  localparam int QD_W    = fas_pkg::RAW_W + DEP_W;
  localparam logic [MUL_W-1:0] MUL_M =
    MUL_W'(((2 ** SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH);
  localparam logic [DEP_W-1:0] DEPTH_V = DEP_W'(TABLE_DEPTH);

  logic [fas_pkg::RAW_W-1:0] raw_r;
  logic [fas_pkg::RAW_W-1:0] q_r;
  logic [fas_pkg::RAW_W-1:0] q_nxt;
  logic [PROD_W-1:0]         prod;
  logic [QD_W-1:0]           qd;
  logic [QD_W-1:0]           rem_full;

  assign prod  = {{fas_pkg::RAW_W{1'b0}}, MUL_M} * {{MUL_W{1'b0}}, raw_i};
  assign q_nxt = prod[SHIFT +: fas_pkg::RAW_W];

  always_ff @(posedge clk) begin
    raw_r <= raw_i;
    q_r   <= q_nxt;
  end

  assign qd       = {{DEP_W{1'b0}}, q_r} * {{fas_pkg::RAW_W{1'b0}}, DEPTH_V};
  assign rem_full = {{DEP_W{1'b0}}, raw_r} - qd;
  assign addr_o   = rem_full[AW-1:0];

endmodule

/* rtl/frame_animation_sequencer.sv */
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+-------------------------
// request  | in_command, in_address, in_data              | start high, busy low
// result   | out_pose, out_hit_box, out_done_res          | out_valid, one cycle
//
// Each table access passes through address reduction, RAM read and data.
// Load writes one entry, start reads the frame count (start-if-different skips
// it when it keeps the base), tick makes up to six table reads through the
// single RAM port. busy stays high until the strobe; the next request is taken
// in the strobe cycle. Synchronous reset returns to idle and clears base,
// offset and frame count; the table is undefined until loaded. The receiver
// cannot stall; each result is shown for exactly one cycle.
module frame_animation_sequencer #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_address,
  input  logic [7:0] in_data,
  output logic       out_valid,
  output logic [7:0] out_pose,
  output logic [7:0] out_hit_box,
  output logic       out_done_res
);

  localparam int AW = $clog2(TABLE_DEPTH);

  fas_pkg::state_t state_r, state_nxt;
  fas_pkg::phase_t phase_r, phase_nxt;
  fas_pkg::cmd_t   cmd;

  logic [fas_pkg::REL_W-1:0]  rel_r, rel_nxt;
  logic [fas_pkg::DATA_W-1:0] base_r, base_nxt;
  logic [fas_pkg::DATA_W-1:0] off_r, off_nxt;
  logic [fas_pkg::DATA_W-1:0] frames_r, frames_nxt;
  logic [fas_pkg::DATA_W-1:0] addr_r, addr_nxt;
  logic [fas_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [fas_pkg::DATA_W-1:0] pose_r, pose_nxt;
  logic [fas_pkg::DATA_W-1:0] hit_r, hit_nxt;
  logic                       done_r, done_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [fas_pkg::DATA_W-1:0] off_p3;
  logic [fas_pkg::DATA_W-1:0] tgt3;
  logic [fas_pkg::RAW_W-1:0]  raw;
  logic [AW-1:0]              ram_addr;
  logic [fas_pkg::DATA_W-1:0] ram_rdata;
  logic                       ram_we;

  assign cmd    = fas_pkg::cmd_t'(in_command);
  assign off_p3 = off_r + 8'd3;
  assign tgt3   = ram_rdata + {ram_rdata[6:0], 1'b0};

  assign raw = (phase_r == fas_pkg::P_WRITE) ? {2'b00, addr_r}
                                             : {2'b00, base_r} + {1'b0, rel_r};

  fas_addr_mod #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_addr_mod (
    .clk   (clk),
    .raw_i (raw),
    .addr_o(ram_addr)
  );

  assign ram_we = (state_r == fas_pkg::ST_MEM) && (phase_r == fas_pkg::P_WRITE);

  fas_ram #(
    .WIDTH(fas_pkg::DATA_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(data_r),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fas_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fas_pkg::ST_ADDR;
        end
      end
      fas_pkg::ST_ADDR: begin
        state_nxt = fas_pkg::ST_MEM;
      end
      fas_pkg::ST_MEM: begin
        if (phase_r == fas_pkg::P_WRITE) begin
          state_nxt = fas_pkg::ST_ADDR;
        end else begin
          state_nxt = fas_pkg::ST_DATA;
        end
      end
      fas_pkg::ST_DATA: begin
        if (phase_r == fas_pkg::P_END) begin
          state_nxt = fas_pkg::ST_IDLE;
        end else begin
          state_nxt = fas_pkg::ST_ADDR;
        end
      end
      default: state_nxt = fas_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_nxt     = phase_r;
    rel_nxt       = rel_r;
    base_nxt      = base_r;
    off_nxt       = off_r;
    frames_nxt    = frames_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    pose_nxt      = pose_r;
    hit_nxt       = hit_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      fas_pkg::ST_IDLE: begin
        if (start) begin
          addr_nxt  = in_address;
          data_nxt  = in_data;
          phase_nxt = fas_pkg::P_POSE;
          rel_nxt   = {1'b0, off_r};
          case (cmd)
            fas_pkg::CMD_LOAD: begin
              phase_nxt = fas_pkg::P_WRITE;
            end
            fas_pkg::CMD_START: begin
              base_nxt  = in_address;
              off_nxt   = '0;
              phase_nxt = fas_pkg::P_COUNT;
              rel_nxt   = 9'd1;
            end
            fas_pkg::CMD_START_DIFF: begin
              if (in_address != base_r) begin
                base_nxt  = in_address;
                off_nxt   = '0;
                phase_nxt = fas_pkg::P_COUNT;
                rel_nxt   = 9'd1;
              end
            end
            fas_pkg::CMD_TICK: begin
              if (frames_r == 8'd1) begin
                // Triple ends: fetch the code after it
                frames_nxt = '0;
                phase_nxt  = fas_pkg::P_OP;
                rel_nxt    = {1'b0, off_p3};
              end else if (frames_r != 8'd0) begin
                frames_nxt = frames_r - 8'd1;
              end
            end
            default: ;
          endcase
        end
      end
      fas_pkg::ST_MEM: begin
        if (phase_r == fas_pkg::P_WRITE) begin
          phase_nxt = fas_pkg::P_POSE;
          rel_nxt   = {1'b0, off_r};
        end
      end
      fas_pkg::ST_DATA: begin
        case (phase_r)
          fas_pkg::P_COUNT: begin
            frames_nxt = ram_rdata;
            phase_nxt  = fas_pkg::P_POSE;
            rel_nxt    = {1'b0, off_r};
          end
          fas_pkg::P_OP: begin
            if (ram_rdata == fas_pkg::CODE_LOOP) begin
              phase_nxt = fas_pkg::P_TARGET;
              rel_nxt   = {1'b0, off_p3} + 9'd1;
            end else if (ram_rdata == fas_pkg::CODE_HOLD ||
                         ram_rdata == fas_pkg::CODE_END) begin
              // Freeze on the current triple
              phase_nxt = fas_pkg::P_POSE;
              rel_nxt   = {1'b0, off_r};
            end else begin
              off_nxt   = off_p3;
              phase_nxt = fas_pkg::P_COUNT;
              rel_nxt   = {1'b0, off_p3} + 9'd1;
            end
          end
          fas_pkg::P_TARGET: begin
            off_nxt   = tgt3;
            phase_nxt = fas_pkg::P_COUNT;
            rel_nxt   = {1'b0, tgt3} + 9'd1;
          end
          fas_pkg::P_POSE: begin
            pose_nxt  = ram_rdata;
            phase_nxt = fas_pkg::P_HIT;
            rel_nxt   = {1'b0, off_r} + 9'd2;
          end
          fas_pkg::P_HIT: begin
            hit_nxt   = ram_rdata;
            phase_nxt = fas_pkg::P_END;
            rel_nxt   = {1'b0, off_r} + 9'd3;
          end
          fas_pkg::P_END: begin
            done_nxt      = (frames_r == 8'd0) && (ram_rdata == fas_pkg::CODE_END);
            out_valid_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fas_pkg::ST_IDLE;
      phase_r     <= fas_pkg::P_POSE;
      base_r      <= '0;
      off_r       <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      off_r       <= off_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_r  <= rel_nxt;
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    pose_r <= pose_nxt;
    hit_r  <= hit_nxt;
    done_r <= done_nxt;
  end

  assign busy         = (state_r != fas_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_pose     = pose_r;
  assign out_hit_box  = hit_r;
  assign out_done_res = done_r;

endmodule

/* tb/frame_animation_sequencer_tb.sv */
`timescale 1ns / 1ps

module frame_animation_sequencer_tb;

  localparam int ITEM_TARGET = 1700;
  localparam int CALM_FROM   = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [7:0] pose;
    logic [7:0] hit_box;
    logic       done_res;
    bit         pose_known;
    bit         hit_known;
    bit         done_known;
  } frame_result_t;

  typedef struct packed {
    fas_pkg::cmd_t cmd;
    logic [7:0]    addr;
    logic [7:0]    data;
    logic          typed;
    logic [7:0]    pose;
    logic [7:0]    hit_box;
    logic          done_res;
  } request_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_command = 2'd0;
  logic [7:0] in_address = 8'd0;
  logic [7:0] in_data = 8'd0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_pose;
  logic [7:0] out_hit_box;
  logic       out_done_res;

  // Shadow of the sequencer state
  logic [7:0] anim_table [256];
  bit         anim_written [256];
  logic [7:0] seq_base = 8'd0;
  logic [7:0] seq_offset = 8'd0;
  logic [7:0] seq_frames = 8'd0;

  frame_result_t expected_frames [$];
  int mismatches = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  // Directed part: table rows run on a preloaded table of 8'h01 bytes
  request_row_t script [25] = '{
    '{fas_pkg::CMD_START_DIFF, 8'h00, 8'h00, 1'b1, 8'h01, 8'h01, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b1, 8'h01, 8'h01, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'hfc, 8'haa, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'hfd, 8'h02, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'hfe, 8'h55, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'hff, fas_pkg::CODE_LOOP, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_START,      8'hfc, 8'hff, 1'b1, 8'haa, 8'h55, 1'b0},
    '{fas_pkg::CMD_TICK,       8'hff, 8'h00, 1'b1, 8'haa, 8'h55, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'hff, 1'b1, 8'haa, 8'h55, 1'b0},
    '{fas_pkg::CMD_START_DIFF, 8'hfc, 8'h00, 1'b1, 8'haa, 8'h55, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'hff, fas_pkg::CODE_END, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b1, 8'haa, 8'h55, 1'b1},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b1, 8'haa, 8'h55, 1'b1},
    '{fas_pkg::CMD_LOAD,       8'hff, fas_pkg::CODE_HOLD, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_START,      8'hfc, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'hff, 8'h33, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b1, 8'h33, 8'h01, 1'b0},
    // loop target 85 puts the triple offset at 255, then offset + 3 wraps
    '{fas_pkg::CMD_LOAD,       8'h13, fas_pkg::CODE_LOOP, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_LOAD,       8'h14, 8'h55, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_START,      8'h10, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
    '{fas_pkg::CMD_TICK,       8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0}
  };

  frame_animation_sequencer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_address   (in_address),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_pose     (out_pose),
    .out_hit_box  (out_hit_box),
    .out_done_res (out_done_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] table_at(input logic [7:0] off);
    return anim_table[8'(seq_base + off)];
  endfunction

  function automatic bit written_at(input logic [7:0] off);
    return anim_written[8'(seq_base + off)];
  endfunction

  function automatic void restart_at(input logic [7:0] addr);
    seq_base = addr;
    seq_offset = 8'd0;
    seq_frames = table_at(8'd1);
  endfunction

  function automatic frame_result_t advance_sequencer(input fas_pkg::cmd_t cmd,
                                                      input logic [7:0] addr,
                                                      input logic [7:0] data);
    frame_result_t r;
    logic [7:0] p;
    logic [7:0] op;
    case (cmd)
      fas_pkg::CMD_LOAD: begin
        anim_table[addr] = data;
        anim_written[addr] = 1'b1;
      end
      fas_pkg::CMD_START: restart_at(addr);
      fas_pkg::CMD_START_DIFF: begin
        if (addr != seq_base) restart_at(addr);
      end
      default: begin
        if (seq_frames != 8'd0) begin
          seq_frames = seq_frames - 8'd1;
          if (seq_frames == 8'd0) begin
            p = seq_offset + 8'd3;
            op = table_at(p);
            if (op == fas_pkg::CODE_LOOP) p = 8'(table_at(p + 8'd1) * 3);
            // hold and end freeze on the current triple with the count at zero
            if (op != fas_pkg::CODE_HOLD && op != fas_pkg::CODE_END) begin
              seq_offset = p;
              seq_frames = table_at(p + 8'd1);
            end
          end
        end
      end
    endcase
    r.pose = table_at(seq_offset);
    r.pose_known = written_at(seq_offset);
    r.hit_box = table_at(seq_offset + 8'd2);
    r.hit_known = written_at(seq_offset + 8'd2);
    r.done_res = (seq_frames == 8'd0) && (table_at(seq_offset + 8'd3) == fas_pkg::CODE_END);
    r.done_known = (seq_frames != 8'd0) || written_at(seq_offset + 8'd3);
    return r;
  endfunction

  function automatic request_row_t make_req(input fas_pkg::cmd_t cmd,
                                            input logic [7:0] addr,
                                            input logic [7:0] data);
    return '{cmd, addr, data, 1'b0, 8'h00, 8'h00, 1'b0};
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic hold_off(input int cycles);
    if (start) start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(input request_row_t row);
    frame_result_t want;
    if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
    in_command <= row.cmd;
    in_address <= row.addr;
    in_data <= row.data;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    want = advance_sequencer(row.cmd, row.addr, row.data);
    if (row.typed) begin
      want = '{row.pose, row.hit_box, row.done_res, 1'b1, 1'b1, 1'b1};
    end
    expected_frames.push_back(want);
    items_sent++;
  endtask

  // Load one sequence at a random base, start it and tick through it, at most 24 ticks
  task automatic play_sequence();
    logic [7:0] base;
    logic [7:0] pose;
    logic [7:0] count;
    logic [7:0] image [$];
    int n;
    int frames_total;
    int ticks;
    base = 8'($urandom_range(0, 255));
    n = $urandom_range(1, 4);
    frames_total = 0;
    for (int k = 0; k < n; k++) begin
      // a later pose must not look like a control code
      do pose = 8'($urandom_range(0, 255)); while (k != 0 && pose >= fas_pkg::CODE_END);
      case ($urandom_range(0, 15))
        0: count = 8'd0;
        1: count = 8'($urandom_range(4, 12));
        default: count = 8'($urandom_range(1, 3));
      endcase
      frames_total += count;
      image.push_back(pose);
      image.push_back(count);
      image.push_back(8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        image.push_back(fas_pkg::CODE_LOOP);
        if ($urandom_range(0, 3) == 0) image.push_back(8'($urandom_range(0, 255)));
        else image.push_back(8'($urandom_range(0, n - 1)));
      end
      3: image.push_back(fas_pkg::CODE_HOLD);
      4, 5: image.push_back(fas_pkg::CODE_END);
      default: begin
        image.push_back(8'($urandom_range(0, 255)));
        image.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    foreach (image[k]) send_request(make_req(fas_pkg::CMD_LOAD, 8'(base + k), image[k]));
    send_request(make_req($urandom_range(0, 1) ? fas_pkg::CMD_START : fas_pkg::CMD_START_DIFF,
                          base, 8'($urandom_range(0, 255))));
    ticks = frames_total + $urandom_range(0, 4);
    if (ticks > 24) ticks = 24;
    repeat (ticks) begin
      send_request(make_req(fas_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255))));
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: pose %h hit_box %h done %b",
                                  out_pose, out_hit_box, out_done_res));
      end else begin
        want = expected_frames.pop_front();
        if (want.pose_known && out_pose !== want.pose)
          report_mismatch($sformatf("pose %h, want %h", out_pose, want.pose));
        if (want.hit_known && out_hit_box !== want.hit_box)
          report_mismatch($sformatf("hit_box %h, want %h", out_hit_box, want.hit_box));
        if (want.done_known && out_done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, want %b", out_done_res, want.done_res));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frame_animation_sequencer: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // Fill the whole table first so no later request reads an unwritten entry
    for (int k = 0; k < 256; k++) send_request(make_req(fas_pkg::CMD_LOAD, 8'(k), 8'h01));
    foreach (script[k]) send_request(script[k]);
    drain();
    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < CALM_FROM) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(make_req(fas_pkg::cmd_t'($urandom_range(0, 3)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end
      end else begin
        play_sequence();
      end
      if (items_sent < CALM_FROM && $urandom_range(0, 15) == 0) drain();
    end
    drain();
    hold_off(24);
    if (mismatches == 0) begin
      $display("frame_animation_sequencer: match");
    end else begin
      $display("frame_animation_sequencer: mismatch");
    end
    $finish;
  end

endmodule

/* frame_animation_sequencer.f */
rtl/fas_pkg.sv
rtl/fas_ram.sv
rtl/fas_addr_mod.sv
rtl/frame_animation_sequencer.sv
tb/frame_animation_sequencer_tb.sv
